[rtl/vertex_dedup_index_remap_assert.svh]
// Assertion macros used by the vertex welding RTL
`ifndef VERTEX_DEDUP_INDEX_REMAP_ASSERT_SVH
`define VERTEX_DEDUP_INDEX_REMAP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define VDR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define VDR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/vdr_pkg.sv]
// -----------------------------------------------------------------------------
// vdr_pkg
// Types and constants for the vertex welding block.
// -----------------------------------------------------------------------------
package vdr_pkg;

  localparam int unsigned MaxVertices = 256;
  localparam int unsigned IdxW = $clog2(MaxVertices);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [1:0] ReqVertex = 2'd0;
  localparam logic [1:0] ReqIndex  = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatFull   = 2'd1;
  localparam logic [1:0] StatBadIdx = 2'd2;

  localparam logic [1:0] RegPosTol  = 2'd0;
  localparam logic [1:0] RegAttrTol = 2'd1;
  localparam logic [1:0] RegMask    = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [47:0]        normal_packed;
    logic [31:0]        uv_packed;
    logic [31:0]        color_packed;
    logic [31:0]        bone_ids;
    logic [63:0]        bone_weights;
    logic [7:0]         old_index;
  } in_item_t;

  typedef struct packed {
    logic       kept;
    logic [7:0] new_index;
    logic [1:0] status;
  } out_item_t;

  // vertex attributes as stored per survivor
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [47:0] normal;
    logic [31:0] uv;
    logic [31:0] color;
    logic [31:0] bones;
    logic [63:0] weights;
  } vtx_t;

  typedef struct packed {
    logic [15:0] pos_tol;
    logic [11:0] attr_tol;
    logic [3:0]  mask;
  } cfg_t;

  // |a-b| <= tol on signed values of up to 33 bits, sign-extended to 34
  function automatic logic close_s(logic signed [32:0] a, logic signed [32:0] b,
                                   logic [15:0] tol);
    logic signed [33:0] d;
    d = {a[32], a} - {b[32], b};
    if (d[33]) d = -d;
    return d <= $signed({18'd0, tol});
  endfunction

  function automatic logic vtx_match(vtx_t s, vtx_t v, cfg_t c);
    logic ok;
    ok = close_s({s.pos_x[31], s.pos_x}, {v.pos_x[31], v.pos_x}, c.pos_tol) &&
         close_s({s.pos_y[31], s.pos_y}, {v.pos_y[31], v.pos_y}, c.pos_tol) &&
         close_s({s.pos_z[31], s.pos_z}, {v.pos_z[31], v.pos_z}, c.pos_tol);
    if (c.mask[0]) begin
      for (int k = 0; k < 3; k++) begin
        ok &= close_s({{17{s.normal[16*k+15]}}, s.normal[16*k +: 16]},
                      {{17{v.normal[16*k+15]}}, v.normal[16*k +: 16]},
                      {4'd0, c.attr_tol});
      end
    end
    if (c.mask[1]) begin
      for (int k = 0; k < 2; k++) begin
        ok &= close_s({17'd0, s.uv[16*k +: 16]}, {17'd0, v.uv[16*k +: 16]},
                      {4'd0, c.attr_tol});
      end
    end
    if (c.mask[2]) begin
      for (int k = 0; k < 4; k++) begin
        ok &= close_s({25'd0, s.color[8*k +: 8]}, {25'd0, v.color[8*k +: 8]},
                      {4'd0, c.attr_tol});
      end
    end
    if (c.mask[3]) begin
      ok &= (s.bones == v.bones);
      for (int k = 0; k < 4; k++) begin
        ok &= close_s({17'd0, s.weights[16*k +: 16]}, {17'd0, v.weights[16*k +: 16]},
                      {4'd0, c.attr_tol});
      end
    end
    return ok;
  endfunction

endpackage

[rtl/vdr_ram.sv]
// -----------------------------------------------------------------------------
// vdr_ram
// Generic single-port-write RAM with one registered read port.
// -----------------------------------------------------------------------------
module vdr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/vdr_cell.sv]
// -----------------------------------------------------------------------------
// vdr_cell
// One survivor slot: holds a vertex, compares the passing probe against it and
// forwards the probe to its neighbor.
// -----------------------------------------------------------------------------
module vdr_cell import vdr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic load_i,
  input  vtx_t load_vtx_i,
  input  cfg_t cfg_i,
  input  logic probe_vld_i,
  input  vtx_t probe_i,
  input  logic hit_i,
  input  logic [IdxW-1:0] hit_idx_i,
  input  logic [IdxW-1:0] my_idx_i,
  output logic probe_vld_o,
  output vtx_t probe_o,
  output logic hit_o,
  output logic [IdxW-1:0] hit_idx_o
);
  vtx_t slot_q;
  logic full_q;
  logic m;

  assign m = full_q && vtx_match(slot_q, probe_i, cfg_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      probe_vld_o <= 1'b0;
    end else begin
      if (clear_i) full_q <= 1'b0;
      else if (load_i) full_q <= 1'b1;
      probe_vld_o <= probe_vld_i && !clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) slot_q <= load_vtx_i;
    probe_o <= probe_i;
    hit_o <= hit_i || m;
    hit_idx_o <= hit_i ? hit_idx_i : my_idx_i;
  end
endmodule

[rtl/vertex_dedup_index_remap.sv]
// -----------------------------------------------------------------------------
// vertex_dedup_index_remap
// Vertex welding with index remap. A vertex beat walks a chain of MaxVertices
// compare cells, one cell per cycle; the earliest matching survivor wins.
// Index beats read the map RAM and pass through St_Map and St_Out; clear and
// unused beats go straight to St_Out. One item is in flight at a time; the
// output register frees the input once the result is taken.
// -----------------------------------------------------------------------------
module vertex_dedup_index_remap import vdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);
  `include "vertex_dedup_index_remap_assert.svh"

  typedef enum logic [1:0] {St_Idle, St_Walk, St_Map, St_Out} st_e;

  st_e st_q;
  cfg_t cfg_q;
  in_item_t item_q;
  logic [CntW-1:0] surv_q, load_q;
  out_item_t res_q;

  logic vld [MaxVertices+1];
  vtx_t prb [MaxVertices+1];
  logic hit [MaxVertices+1];
  logic [IdxW-1:0] hidx [MaxVertices+1];
  logic [MaxVertices-1:0] load_v;
  vtx_t vin;
  logic start, walk_done;
  logic map_we;
  logic [IdxW-1:0] map_rd;
  logic [IdxW-1:0] map_wd;
  logic walk_hit;

  assign vin = '{pos_x: item_q.pos_x, pos_y: item_q.pos_y, pos_z: item_q.pos_z,
                 normal: item_q.normal_packed, uv: item_q.uv_packed,
                 color: item_q.color_packed, bones: item_q.bone_ids,
                 weights: item_q.bone_weights};

  assign in_ready_o = (st_q == St_Idle) && !out_valid_o;
  assign start = (st_q == St_Idle) && in_valid_i && in_ready_o
                 && in_data_i.req_type == ReqVertex;
  assign vld[0] = start;
  assign prb[0] = '{pos_x: in_data_i.pos_x, pos_y: in_data_i.pos_y,
                    pos_z: in_data_i.pos_z, normal: in_data_i.normal_packed,
                    uv: in_data_i.uv_packed, color: in_data_i.color_packed,
                    bones: in_data_i.bone_ids, weights: in_data_i.bone_weights};
  assign hit[0] = 1'b0;
  assign hidx[0] = '0;
  assign walk_done = vld[MaxVertices];

  for (genvar g = 0; g < MaxVertices; g++) begin : g_cell
    assign load_v[g] = walk_done && !walk_hit && load_q < CntW'(MaxVertices)
                       && surv_q < CntW'(MaxVertices) && surv_q[IdxW-1:0] == IdxW'(g);
    vdr_cell u_cell (
      .clk_i, .rst_ni,
      .clear_i(1'b0),
      .load_i(load_v[g]), .load_vtx_i(vin), .cfg_i(cfg_q),
      .probe_vld_i(vld[g]), .probe_i(prb[g]),
      .hit_i(hit[g]), .hit_idx_i(hidx[g]), .my_idx_i(IdxW'(g)),
      .probe_vld_o(vld[g+1]), .probe_o(prb[g+1]),
      .hit_o(hit[g+1]), .hit_idx_o(hidx[g+1])
    );
  end

  // cells only count as full below surv_q: stale slots are masked by the count
  // through the hit chain being gated below
  assign walk_hit = hit[MaxVertices] && CntW'(hidx[MaxVertices]) < surv_q;
  assign map_we = walk_done && load_q < CntW'(MaxVertices)
                  && (walk_hit || surv_q < CntW'(MaxVertices));
  assign map_wd = walk_hit ? hidx[MaxVertices] : surv_q[IdxW-1:0];
  // read launched on the accepting edge so the data is ready in St_Map
  assign map_rd = in_data_i.old_index[IdxW-1:0];

  logic [IdxW-1:0] map_q;
  vdr_ram #(.Width(IdxW), .Depth(MaxVertices)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(load_q[IdxW-1:0]), .wdata_i(map_wd),
    .raddr_i(map_rd), .rdata_o(map_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= St_Idle;
      cfg_q <= '{pos_tol: 16'd1, attr_tol: 12'd1, mask: 4'd0};
      surv_q <= '0;
      load_q <= '0;
      out_valid_o <= 1'b0;
      res_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegPosTol:  cfg_q.pos_tol <= cfg_data_i;
          RegAttrTol: cfg_q.attr_tol <= cfg_data_i[11:0];
          RegMask:    cfg_q.mask <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (st_q)
        St_Idle: if (in_valid_i && in_ready_o) begin
          res_q <= '0;
          unique case (in_data_i.req_type)
            ReqVertex: st_q <= St_Walk;
            ReqIndex:  st_q <= St_Map;
            ReqClear: begin
              surv_q <= '0;
              load_q <= '0;
              st_q <= St_Out;
            end
            default: st_q <= St_Out;
          endcase
        end
        St_Walk: if (walk_done) begin
          if (load_q >= CntW'(MaxVertices)) res_q.status <= StatFull;
          else if (walk_hit) begin
            res_q.new_index <= 8'(hidx[MaxVertices]);
            load_q <= load_q + 1'b1;
          end else if (surv_q >= CntW'(MaxVertices)) res_q.status <= StatFull;
          else begin
            res_q.kept <= 1'b1;
            res_q.new_index <= 8'(surv_q[IdxW-1:0]);
            surv_q <= surv_q + 1'b1;
            load_q <= load_q + 1'b1;
          end
          st_q <= St_Out;
        end
        St_Map: begin
          if (CntW'(item_q.old_index) < load_q) res_q.new_index <= 8'(map_q);
          else res_q.status <= StatBadIdx;
          st_q <= St_Out;
        end
        St_Out: begin
          out_valid_o <= 1'b1;
          st_q <= St_Idle;
        end
        default: st_q <= St_Idle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
  end

  assign out_data_o = res_q;

  `VDR_ASSERT_IMP(a_ready_idle, in_ready_o, st_q == St_Idle)
  `VDR_ASSERT_IMP(a_cnt_order, 1'b1, surv_q <= load_q)
  `VDR_ASSERT_NXT(a_kept_ok, st_q == St_Out, !res_q.kept || res_q.status == StatOk)
endmodule
